@@ sv/pckt_pkg.sv @@
// ----------------------------------------------------------------------------
// pckt_pkg: particle colour keyframe tween shared types and constants
// Word layouts, register indexes, sequencer states and fixed-point limits.
// ----------------------------------------------------------------------------
package pckt_pkg;

    localparam int TARGET_SLOTS = 6;
    localparam int DIV_STEPS    = 40;
    localparam int MUL_STEPS    = 16;

    localparam logic [3:0]  SEG_NONE  = 4'hF;
    localparam logic [23:0] CH_MAX    = 24'hFF_0000;
    localparam logic signed [39:0] SLOPE_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] SLOPE_MIN = 40'sh80_0000_0000;

    // configuration register indexes
    localparam logic [2:0] REG_SEGMENT_TIME = 3'd0;
    localparam logic [2:0] REG_COLOR_COUNT  = 3'd1;
    localparam logic [2:0] REG_TARGET_FIRST = 3'd2;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_RESPAWN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEGDIV,
        ST_SEGCHK,
        ST_SLOPEDIV,
        ST_SLOPESET,
        ST_MUL,
        ST_APPLY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               func;
        logic [15:0]        dt;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        start_color;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_alpha;
        logic [2:0]         segment;
    } result_t;

endpackage

@@ sv/pckt_stream_if.sv @@
// ----------------------------------------------------------------------------
// pckt_stream_if: valid/ready stream channel
// Carries one payload word per handshake.
// ----------------------------------------------------------------------------
interface pckt_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ sv/particle_color_keyframe_tween_core.sv @@
// ----------------------------------------------------------------------------
// particle_color_keyframe_tween_core: one particle, colour gradient over life
// Timer, motion and per-channel colour slopes, worked bit-serially.
// ----------------------------------------------------------------------------
//  channel   direction  word       handshake
//  item      in         item_t     valid/ready
//  result    out        result_t   valid/ready
//  cfg       in         index/data write enable, no read-back
//
// A respawn word goes straight to the emit state. For a tick word a 40-step
// restoring divider finds the segment and, when the segment advances, the four
// slopes (four lanes), and a 16-step shift-and-add multiplier over dt scales
// velocity and slopes. Reset is asynchronous and active low.
// A stalled result holds in the output register; the next word is taken as
// soon as a result moves into that register, and a word that finishes while
// it is still full waits in the emit state.
module particle_color_keyframe_tween_core #(
    parameter int MAX_COLORS = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    pckt_stream_if.sink            item,
    pckt_stream_if.source          result,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_wdata
);
    import pckt_pkg::*;

    state_t state_reg, state_next;

    logic [31:0]        seg_time_reg;
    logic [2:0]         color_count_reg;
    logic [31:0]        target_reg [TARGET_SLOTS];

    logic [31:0]        timer_reg;
    logic [3:0]         seg_reg;
    logic [23:0]        value_reg [4];
    logic signed [39:0] slope_reg [4];
    logic signed [31:0] pos_reg [2];
    logic signed [31:0] vel_reg [2];

    logic [15:0]        dt_reg;
    logic [5:0]         step_reg;
    logic [39:0]        dvd_reg [4];
    logic [31:0]        rem_reg [4];
    logic               neg_reg [4];
    logic signed [55:0] acc_reg [6];

    result_t            out_reg;
    logic               out_valid_reg;

    logic [31:0]        seg_div;
    logic [2:0]         cnt_m1;
    logic [32:0]        timer_sum;
    logic [31:0]        timer_new;
    logic [31:0]        quot;
    logic [2:0]         num_new;
    logic               advance;
    logic               take_item;
    logic               load_out;

    // effective divisor and colour count
    always_comb
    begin
        seg_div = (seg_time_reg == 32'd0) ? 32'd1 : seg_time_reg;
        if (color_count_reg == 3'd0)
            cnt_m1 = 3'd0;
        else if (color_count_reg > 3'(MAX_COLORS))
            cnt_m1 = 3'(MAX_COLORS - 1);
        else
            cnt_m1 = color_count_reg - 3'd1;
        timer_sum = {1'b0, timer_reg} + {17'd0, item.data.dt};
        timer_new = timer_sum[32] ? 32'hFFFF_FFFF : timer_sum[31:0];
        quot      = dvd_reg[0][31:0];
        num_new   = (quot > {29'd0, cnt_m1}) ? cnt_m1 : quot[2:0];
        advance   = (seg_reg == SEG_NONE) || ({1'b0, num_new} > seg_reg);
    end

    assign take_item    = item.valid && item.ready;
    assign item.ready   = (state_reg == ST_IDLE);
    assign load_out     = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_item)
                    state_next = (item.data.func == FUNC_RESPAWN) ? ST_EMIT : ST_SEGDIV;
            end
            ST_SEGDIV:
            begin
                if (step_reg == 6'(DIV_STEPS - 1))
                    state_next = ST_SEGCHK;
            end
            ST_SEGCHK:    state_next = advance ? ST_SLOPEDIV : ST_MUL;
            ST_SLOPEDIV:
            begin
                if (step_reg == 6'(DIV_STEPS - 1))
                    state_next = ST_SLOPESET;
            end
            ST_SLOPESET:  state_next = ST_MUL;
            ST_MUL:
            begin
                if (step_reg == 6'(MUL_STEPS - 1))
                    state_next = ST_APPLY;
            end
            ST_APPLY:     state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_time_reg    <= 32'h0001_0000;
            color_count_reg <= 3'd1;
            for (int i = 0; i < TARGET_SLOTS; i++)
                target_reg[i] <= 32'd0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_SEGMENT_TIME)
                seg_time_reg <= cfg_wdata;
            else if (cfg_index == REG_COLOR_COUNT)
                color_count_reg <= cfg_wdata[2:0];
            else
                target_reg[cfg_index - REG_TARGET_FIRST] <= cfg_wdata;
        end
    end

    // particle state and serial datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [32:0]        trial;
        logic               qbit;
        logic signed [24:0] diff;
        logic [23:0]        mag;
        logic               bit_in;
        logic signed [55:0] mcand;
        logic signed [32:0] psum;
        logic signed [41:0] csum;
        if (!rst_n)
        begin
            timer_reg <= 32'd0;
            seg_reg   <= SEG_NONE;
            for (int c = 0; c < 4; c++)
            begin
                value_reg[c] <= (c == 3) ? CH_MAX : 24'd0;
                slope_reg[c] <= 40'sd0;
            end
            for (int a = 0; a < 2; a++)
            begin
                pos_reg[a] <= 32'sd0;
                vel_reg[a] <= 32'sd0;
            end
            step_reg <= 6'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= 6'd0;
                    if (take_item)
                    begin
                        if (item.data.func == FUNC_RESPAWN)
                        begin
                            pos_reg[0] <= item.data.pos_x;
                            pos_reg[1] <= item.data.pos_y;
                            vel_reg[0] <= item.data.vel_x;
                            vel_reg[1] <= item.data.vel_y;
                            for (int c = 0; c < 4; c++)
                                value_reg[c] <= {item.data.start_color[31 - 8 * c -: 8], 16'd0};
                            timer_reg <= 32'd0;
                            seg_reg   <= SEG_NONE;
                        end
                        else
                        begin
                            timer_reg  <= timer_new;
                            dt_reg     <= item.data.dt;
                            dvd_reg[0] <= {8'd0, timer_new};
                            rem_reg[0] <= 32'd0;
                        end
                    end
                end
                ST_SEGDIV, ST_SLOPEDIV:
                begin
                    // one restoring division step in each lane
                    for (int c = 0; c < 4; c++)
                    begin
                        trial = {rem_reg[c], dvd_reg[c][39]};
                        qbit  = (trial >= {1'b0, seg_div});
                        rem_reg[c] <= qbit ? 32'(trial - {1'b0, seg_div}) : trial[31:0];
                        dvd_reg[c] <= {dvd_reg[c][38:0], qbit};
                    end
                    step_reg <= (step_reg == 6'(DIV_STEPS - 1)) ? 6'd0 : step_reg + 6'd1;
                end
                ST_SEGCHK:
                begin
                    step_reg <= 6'd0;
                    if (advance)
                        seg_reg <= {1'b0, num_new};
                    // load slope dividends from the new target
                    for (int c = 0; c < 4; c++)
                    begin
                        diff = $signed({1'b0, target_reg[num_new][31 - 8 * c -: 8], 16'd0})
                             - $signed({1'b0, value_reg[c]});
                        mag  = diff[24] ? 24'(-diff) : diff[23:0];
                        neg_reg[c] <= diff[24];
                        dvd_reg[c] <= {mag, 16'd0};
                        rem_reg[c] <= 32'd0;
                    end
                    for (int l = 0; l < 6; l++)
                        acc_reg[l] <= 56'sd0;
                end
                ST_SLOPESET:
                begin
                    // saturate quotients into signed slopes
                    for (int c = 0; c < 4; c++)
                    begin
                        if (neg_reg[c])
                            slope_reg[c] <= (dvd_reg[c] > 40'h80_0000_0000) ? SLOPE_MIN
                                          : -$signed(dvd_reg[c]);
                        else
                            slope_reg[c] <= dvd_reg[c][39] ? SLOPE_MAX : $signed(dvd_reg[c]);
                    end
                    step_reg <= 6'd0;
                end
                ST_MUL:
                begin
                    // shift-and-add over dt, high bit first
                    bit_in = dt_reg[15];
                    for (int l = 0; l < 6; l++)
                    begin
                        mcand = (l < 2) ? 56'(vel_reg[l % 2]) : 56'(slope_reg[(l + 2) % 4]);
                        acc_reg[l] <= (acc_reg[l] <<< 1) + (bit_in ? mcand : 56'sd0);
                    end
                    dt_reg   <= {dt_reg[14:0], 1'b0};
                    step_reg <= (step_reg == 6'(MUL_STEPS - 1)) ? 6'd0 : step_reg + 6'd1;
                end
                ST_APPLY:
                begin
                    for (int a = 0; a < 2; a++)
                    begin
                        psum = 33'(pos_reg[a]) + 33'($signed(acc_reg[a][47:16]));
                        if (psum > 33'sh0_7FFF_FFFF)
                            pos_reg[a] <= 32'sh7FFF_FFFF;
                        else if (psum < -33'sh0_8000_0000)
                            pos_reg[a] <= 32'sh8000_0000;
                        else
                            pos_reg[a] <= psum[31:0];
                    end
                    for (int c = 0; c < 4; c++)
                    begin
                        csum = $signed({18'd0, value_reg[c]})
                             + 42'($signed(acc_reg[c + 2][55:16]));
                        if (csum < 42'sd0)
                            value_reg[c] <= 24'd0;
                        else if (csum > $signed({18'd0, CH_MAX}))
                            value_reg[c] <= CH_MAX;
                        else
                            value_reg[c] <= csum[23:0];
                    end
                end
                default:
                begin
                    step_reg <= 6'd0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.out_x     <= pos_reg[0];
            out_reg.out_y     <= pos_reg[1];
            out_reg.out_red   <= value_reg[0][23:16];
            out_reg.out_green <= value_reg[1][23:16];
            out_reg.out_blue  <= value_reg[2][23:16];
            out_reg.out_alpha <= value_reg[3][23:16];
            out_reg.segment   <= (seg_reg == SEG_NONE) ? 3'd0 : seg_reg[2:0];
        end
    end

    // checks
    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_reg == SEG_NONE) || (seg_reg < 4'(TARGET_SLOTS)))
        else $error("segment register out of range");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not presented after emit");

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (take_item && (item.data.func == FUNC_TICK)) |=> (state_reg == ST_SEGDIV))
        else $error("tick did not start division");

    a_respawn_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take_item && (item.data.func == FUNC_RESPAWN)) |=>
        (seg_reg == SEG_NONE) && (timer_reg == 32'd0))
        else $error("respawn did not clear timer and segment");

endmodule

@@ verif/tb_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_if: note on channel interfaces
// The testbench uses the block's own stream interface; this file carries
// the tick word helper used by the test sequence.
// ----------------------------------------------------------------------------
package tb_words_pkg;

    import pckt_pkg::*;

    // build a tick word
    function automatic item_t make_tick(logic [15:0] dt);
        item_t w;
        w = '0;
        w.func = FUNC_TICK;
        w.dt = dt;
        return w;
    endfunction

endpackage

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: particle colour keyframe tween core
// Drives respawn and tick words under varied idling and register settings,
// predicts position, colour and segment per word and compares each result.
// ----------------------------------------------------------------------------
module testbench;

    import pckt_pkg::*;
    import tb_words_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int MAX_COLORS_TB = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    pckt_stream_if #(.payload_t(item_t)) item_ch ();
    pckt_stream_if #(.payload_t(result_t)) result_ch ();

    particle_color_keyframe_tween_core u_top (
        .clk(clk), .rst_n(rst_n), .item(item_ch.sink), .result(result_ch.source),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] seg_time_r;
    logic [2:0] count_r;
    logic [31:0] target_r [TARGET_SLOTS];
    logic [31:0] timer_p;
    logic [3:0] seg_p;
    longint chan_p [4];
    longint slope_p [4];
    longint pos_p [2];
    longint vel_p [2];

    item_t pending_words [$];
    result_t expected_results [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    bit item_taken = 1'b0;
    int errors = 0;
    int quiet_cycles = 0;
    longint ch_max = 255 * 65536;
    longint slope_max = (64'sd1 <<< 39) - 1;

    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint chan_of(logic [31:0] packed_c, int ch);
        return longint'((packed_c >> (24 - 8 * ch)) & 32'hFF) <<< 16;
    endfunction

    function automatic void reset_model();
        seg_time_r = 32'd65536;
        count_r = 3'd1;
        foreach (target_r[i]) target_r[i] = '0;
        timer_p = '0;
        seg_p = SEG_NONE;
        for (int c = 0; c < 4; c++) begin
            chan_p[c] = 0;
            slope_p[c] = 0;
        end
        chan_p[3] = ch_max;
        pos_p = '{0, 0};
        vel_p = '{0, 0};
    endfunction

    function automatic void write_model(logic [2:0] idx, logic [31:0] v);
        if (idx == REG_SEGMENT_TIME) seg_time_r = v;
        else if (idx == REG_COLOR_COUNT) count_r = v[2:0];
        else if (idx >= REG_TARGET_FIRST) target_r[idx - REG_TARGET_FIRST] = v;
    endfunction

    // advance the particle by one word and return its expected result
    function automatic result_t tween_step(item_t w);
        result_t r;
        longint seg_t, cnt, num, diff, q;
        longint dtv;
        if (w.func == FUNC_RESPAWN) begin
            pos_p[0] = w.pos_x;
            pos_p[1] = w.pos_y;
            vel_p[0] = w.vel_x;
            vel_p[1] = w.vel_y;
            for (int c = 0; c < 4; c++) chan_p[c] = chan_of(w.start_color, c);
            timer_p = '0;
            seg_p = SEG_NONE;
        end else begin
            dtv = w.dt;
            seg_t = seg_time_r == 0 ? 1 : seg_time_r;
            cnt = count_r < 1 ? 1 : (count_r > MAX_COLORS_TB ? MAX_COLORS_TB : count_r);
            timer_p = (32'hFFFF_FFFF - timer_p < w.dt) ? 32'hFFFF_FFFF : timer_p + w.dt;
            for (int a = 0; a < 2; a++)
                pos_p[a] = clampl(pos_p[a] + floor16(vel_p[a] * dtv),
                                  -64'sd2147483648, 64'sd2147483647);
            num = longint'(timer_p) / seg_t;
            if (num > cnt - 1) num = cnt - 1;
            if (seg_p == SEG_NONE || num > seg_p) begin
                seg_p = num[3:0];
                for (int c = 0; c < 4; c++) begin
                    diff = chan_of(target_r[num], c) - chan_p[c];
                    q = ((diff < 0 ? -diff : diff) <<< 16) / seg_t;
                    if (diff < 0) slope_p[c] = q > slope_max + 1 ? -slope_max - 1 : -q;
                    else slope_p[c] = q > slope_max ? slope_max : q;
                end
            end
            for (int c = 0; c < 4; c++)
                chan_p[c] = clampl(chan_p[c] + floor16(slope_p[c] * dtv), 0, ch_max);
        end
        r.out_x = pos_p[0][31:0];
        r.out_y = pos_p[1][31:0];
        r.out_red = chan_p[0][23:16];
        r.out_green = chan_p[1][23:16];
        r.out_blue = chan_p[2][23:16];
        r.out_alpha = chan_p[3][23:16];
        r.segment = seg_p == SEG_NONE ? 3'd0 : seg_p[2:0];
        return r;
    endfunction

    // append one word to the send queue
    task automatic queue_word(item_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    // drive words at the falling edge; drop a word once it has been taken
    always @(negedge clk) begin
        if (item_taken) begin
            void'(pending_words.pop_front());
        end
        if (item_ch.valid && !item_taken) begin
            item_ch.valid <= 1'b1;
        end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            item_ch.data <= pending_words[0];
            item_ch.valid <= 1'b1;
        end else begin
            item_ch.valid <= 1'b0;
        end
        result_ch.ready <= !hold_off && $urandom_range(99) >= recv_stall_pct;
    end

    // predict accepted words, check results, watch progress
    always @(posedge clk) begin
        result_t got, exp_r;
        if (rst_n) begin
            item_taken <= item_ch.valid && item_ch.ready;
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (item_ch.valid && item_ch.ready) begin
                expected_results.insert(expected_results.size(), tween_step(item_ch.data));
            end
            if (result_ch.valid && result_ch.ready) begin
                got = result_ch.data;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        errors++;
                        if (errors <= 10)
                            $display(
                "mismatch: exp x=%h y=%h c=%h%h%h%h s=%0d got x=%h y=%h c=%h%h%h%h s=%0d",
                                exp_r.out_x, exp_r.out_y, exp_r.out_red, exp_r.out_green,
                                exp_r.out_blue, exp_r.out_alpha, exp_r.segment,
                                got.out_x, got.out_y, got.out_red, got.out_green,
                                got.out_blue, got.out_alpha, got.segment);
                    end
                end
            end
            if (quiet_cycles > WATCHDOG && !hold_off) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // write one register while idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        write_model(idx, v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until every word is sent and every result has come
    task automatic drain();
        while (pending_words.size() > 0 || item_ch.valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function automatic item_t random_word(int dt_mode);
        item_t w;
        w.func = ($urandom_range(9) == 0) ? FUNC_RESPAWN : FUNC_TICK;
        case (dt_mode)
            0: w.dt = 16'($urandom_range(4095));
            default: w.dt = 16'($urandom);
        endcase
        w.pos_x = $urandom;
        w.pos_y = $urandom;
        w.vel_x = ($urandom_range(1)) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
        w.vel_y = ($urandom_range(1)) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
        w.start_color = $urandom;
        return w;
    endfunction

    task automatic random_config(int k);
        logic [31:0] st;
        case (k % 4)
            0: st = $urandom_range(65536, 1);
            1: st = 32'hFFFF_FFFF;
            2: st = (k % 8 == 2) ? 32'd0 : 32'd1;
            default: st = $urandom_range(4096, 16);
        endcase
        write_reg(REG_SEGMENT_TIME, st);
        write_reg(REG_COLOR_COUNT, $urandom_range(7));
        for (int i = 0; i < TARGET_SLOTS; i++)
            write_reg(REG_TARGET_FIRST + i[2:0], $urandom);
    endtask

    initial begin
        item_t w;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
        reset_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset state, extremes, zero and large segment time
        queue_word(make_tick(16'd0));
        queue_word(make_tick(16'hFFFF));
        drain();
        write_reg(REG_SEGMENT_TIME, 32'd0);
        write_reg(REG_COLOR_COUNT, 32'd7);
        write_reg(REG_TARGET_FIRST, 32'hFFFF_FFFF);
        write_reg(REG_TARGET_FIRST + 3'd1, 32'h0000_0000);
        write_reg(REG_TARGET_FIRST + 3'd2, 32'h80FF_0080);
        w = '0;
        w.func = FUNC_RESPAWN;
        w.dt = 16'hFFFF;
        w.pos_x = 32'sh7FFF_FFFF;
        w.pos_y = 32'sh8000_0000;
        w.vel_x = 32'sh7FFF_FFFF;
        w.vel_y = 32'sh8000_0000;
        w.start_color = 32'h00FF_00FF;
        queue_word(w);
        repeat (4) queue_word(make_tick(16'hFFFF));
        queue_word(make_tick(16'd1));
        drain();
        write_reg(REG_SEGMENT_TIME, 32'hFFFF_FFFF);
        write_reg(REG_COLOR_COUNT, 32'd0);
        w.start_color = 32'hFFFF_FFFF;
        w.vel_x = -32'sd65536;
        queue_word(w);
        repeat (3) queue_word(make_tick(16'hFFFF));
        drain();
        // count lowered: segment does not move back and is kept
        write_reg(REG_SEGMENT_TIME, 32'd1);
        write_reg(REG_COLOR_COUNT, 32'd6);
        queue_word(make_tick(16'd100));
        drain();
        write_reg(REG_COLOR_COUNT, 32'd2);
        queue_word(make_tick(16'd5));
        drain();

        // random phases across idling patterns and register settings
        for (int ph = 0; ph < 16; ph++) begin
            random_config(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int i = 0; i < 120; i++) queue_word(random_word(ph % 2));
            if (ph == 5) begin
                hold_off = 1'b1;
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
